// File: hdl/csvfs_pkg.sv
package csvfs_pkg;

   localparam int MAX_FIELDS_DEFAULT = 64;
   localparam int QUEUE_DEPTH        = 4;

   localparam logic [7:0] CH_QUOTE        = 8'h22;
   localparam logic [7:0] CH_LF           = 8'h0A;
   localparam logic [7:0] CH_CR           = 8'h0D;
   localparam logic [7:0] DELIMITER_RESET = 8'd44;

   typedef enum logic [1:0] {
      MODE_UNQUOTED   = 2'd0,
      MODE_QUOTED     = 2'd1,
      MODE_AFTERQUOTE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_FIELD  = 2'd1,
      KIND_RECORD = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [5:0]  field_index;
   } result_type;

   // One queue entry: the results caused by one input beat, one or two of them.
   typedef struct packed {
      logic        two;
      result_type  r0;
      result_type  r1;
   } entry_type;

   typedef struct packed {
      logic        valid;
      result_type  res;
      mode_type    mode;
      logic [5:0]  count;
   } parse_out_type;

   // Classify one byte against the current mode; at most one result.
   function automatic parse_out_type parse_byte(
      input mode_type   mode,
      input logic [5:0] cnt,
      input logic [7:0] delim,
      input logic [7:0] c,
      input logic [5:0] cap
   );
      parse_out_type o;
      o.valid           = 1'b0;
      o.res.kind        = KIND_DATA;
      o.res.data_byte   = c;
      o.res.field_index = cnt;
      o.mode            = mode;
      o.count           = cnt;
      unique case (mode)
         MODE_QUOTED: begin
            if (c == CH_QUOTE) begin
               o.mode = MODE_AFTERQUOTE;
            end else begin
               o.valid = 1'b1;
            end
         end
         MODE_AFTERQUOTE: begin
            priority if (c == delim) begin
               o.valid         = 1'b1;
               o.res.kind      = KIND_FIELD;
               o.res.data_byte = 8'd0;
               o.count         = (cnt < cap) ? cnt + 6'd1 : cnt;
               o.mode          = MODE_UNQUOTED;
            end else if (c == CH_QUOTE) begin
               o.valid = 1'b1;
               o.mode  = MODE_QUOTED;
            end else if (c == CH_LF) begin
               o.valid         = 1'b1;
               o.res.kind      = KIND_RECORD;
               o.res.data_byte = 8'd0;
               o.count         = 6'd0;
               o.mode          = MODE_UNQUOTED;
            end else begin
               o.mode = MODE_UNQUOTED;
            end
         end
         default: begin
            priority if (c == delim) begin
               o.valid         = 1'b1;
               o.res.kind      = KIND_FIELD;
               o.res.data_byte = 8'd0;
               o.count         = (cnt < cap) ? cnt + 6'd1 : cnt;
               o.mode          = MODE_UNQUOTED;
            end else if (c == CH_LF) begin
               o.valid         = 1'b1;
               o.res.kind      = KIND_RECORD;
               o.res.data_byte = 8'd0;
               o.count         = 6'd0;
               o.mode          = MODE_UNQUOTED;
            end else if (c == CH_QUOTE) begin
               o.mode = MODE_QUOTED;
            end else begin
               o.valid = 1'b1;
            end
         end
      endcase
      return o;
   endfunction

endpackage

// File: hdl/csvfs_front.sv
module csvfs_front import csvfs_pkg::*; #(
   parameter int MAX_FIELDS = MAX_FIELDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_stream,
   output logic        push,
   output entry_type   push_entry
);

   localparam int FieldCapInt = (MAX_FIELDS - 1 < 63) ? MAX_FIELDS - 1 : 63;
   localparam logic [5:0] FieldCap = 6'(FieldCapInt);

   logic [7:0]    delim_ff;
   mode_type      mode_ff, mode_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          cr_ff, cr_in;

   parse_out_type p_cr, p_byte;
   logic          use_cr, hold_cr;
   mode_type      mode_mid;
   logic [5:0]    cnt_mid;
   logic          first_valid, second_valid;
   result_type    second_res;
   logic          accept;

   assign accept = req_valid && !req_stall;

   always_comb begin
      p_cr     = parse_byte(mode_ff, cnt_ff, delim_ff, CH_CR, FieldCap);
      // Drop the held CR only when an LF follows it outside quotes.
      use_cr   = cr_ff && (req_end_of_stream ||
                 !(req_in_byte == CH_LF && mode_ff != MODE_QUOTED));
      mode_mid = use_cr ? p_cr.mode  : mode_ff;
      cnt_mid  = use_cr ? p_cr.count : cnt_ff;
      first_valid = use_cr && p_cr.valid;
      p_byte   = parse_byte(mode_mid, cnt_mid, delim_ff, req_in_byte, FieldCap);
      hold_cr  = (req_in_byte == CH_CR) && (mode_mid != MODE_QUOTED);

      second_res.kind        = KIND_RECORD;
      second_res.data_byte   = 8'd0;
      second_res.field_index = cnt_mid;
      if (req_end_of_stream) begin
         second_valid = 1'b1;
         mode_in      = MODE_UNQUOTED;
         cnt_in       = 6'd0;
         cr_in        = 1'b0;
      end else if (hold_cr) begin
         second_valid = 1'b0;
         mode_in      = mode_mid;
         cnt_in       = cnt_mid;
         cr_in        = 1'b1;
      end else begin
         second_valid = p_byte.valid;
         second_res   = p_byte.res;
         mode_in      = p_byte.mode;
         cnt_in       = p_byte.count;
         cr_in        = 1'b0;
      end

      push_entry.two = first_valid && second_valid;
      push_entry.r0  = first_valid ? p_cr.res : second_res;
      push_entry.r1  = second_res;
      push           = accept && (first_valid || second_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DELIMITER_RESET;
         mode_ff  <= MODE_UNQUOTED;
         cnt_ff   <= 6'd0;
         cr_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            delim_ff <= csr_wr_data;
         end
         if (accept) begin
            mode_ff <= mode_in;
            cnt_ff  <= cnt_in;
            cr_ff   <= cr_in;
         end
      end
   end

endmodule

// File: hdl/csvfs_queue.sv
module csvfs_queue import csvfs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  entry_type  push_entry,
   input  logic       pop,
   output entry_type  head_entry,
   output logic       not_empty,
   output logic       full
);

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]    count_ff;

   assign head_entry = mem_ff[rd_ptr_ff];
   assign not_empty  = (count_ff != '0);
   assign full       = (count_ff == CntW'(QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

endmodule

// File: hdl/csvfs_back.sv
module csvfs_back import csvfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  entry_type   head_entry,
   input  logic        not_empty,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [5:0]  rsp_field_index,
   output logic        rsp_last
);

   logic        sel_ff, sel_in;
   logic        valid_ff, valid_in;
   result_type  res_ff, cur;
   logic        last_ff, final_res, load;

   always_comb begin
      cur       = sel_ff ? head_entry.r1 : head_entry.r0;
      final_res = !head_entry.two || sel_ff;
      load      = not_empty && (!valid_ff || !rsp_stall);
      pop       = load && final_res;
      sel_in    = load ? !final_res : sel_ff;
      valid_in  = (!valid_ff || !rsp_stall) ? not_empty : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= cur;
         last_ff <= final_res;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = res_ff.kind;
   assign rsp_data_byte   = res_ff.data_byte;
   assign rsp_field_index = res_ff.field_index;
   assign rsp_last        = last_ff;

endmodule

// File: hdl/csv_field_splitter.sv
// Each result goes into the queue, then into the output register. Throughput: one
// input beat per cycle while the queue has room; one result beat per cycle leaves the
// output register unless rsp_stall is high; a beat with two results gives two beats.
// Reset (synchronous, active high): unquoted mode, field index 0, no held CR,
// delimiter comma, queue empty, no result valid.
module csv_field_splitter import csvfs_pkg::*; #(
   parameter int MAX_FIELDS = MAX_FIELDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [5:0]  rsp_field_index,
   output logic        rsp_last
);

   // Front: classify each byte, track mode, field count and held CR, and
   // push the one or two results of the beat as a single queue entry.
   // Queue: a short FIFO that lets the front run on while the output stalls.
   // Back: serialise each entry into result beats and mark the final one.

   logic        push, pop, not_empty, full;
   entry_type   push_entry, head_entry;

   // Stall only when the queue has no room; beats causing no result still
   // need the front, so hold them back too.
   assign req_stall = full;

   csvfs_front #(
      .MAX_FIELDS (MAX_FIELDS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .push              (push),
      .push_entry        (push_entry)
   );

   csvfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .not_empty  (not_empty),
      .full       (full)
   );

   csvfs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_entry      (head_entry),
      .not_empty       (not_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_field_index (rsp_field_index),
      .rsp_last        (rsp_last)
   );

endmodule

// File: dv/csv_field_splitter_checker.sv
`timescale 1ns / 100ps

module csv_field_splitter_checker import csvfs_pkg::*; #(
   parameter int MAX_FIELDS = MAX_FIELDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_stream,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_kind,
   input  logic [7:0]  rsp_data_byte,
   input  logic [5:0]  rsp_field_index,
   input  logic        rsp_last,
   output int          fail_count,
   output int          tokens_owed
);

   localparam int FIELD_CAP = (MAX_FIELDS - 1 < 63) ? MAX_FIELDS - 1 : 63;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [5:0]  field_index;
      logic        last;
   } csv_token_type;

   csv_token_type  parsed_tokens[$];
   csv_token_type  beat_tokens[$];
   mode_type       scan_mode;
   logic [5:0]     field_no;
   logic           cr_waiting;
   logic [7:0]     sep_byte;

   function void push_token(input kind_type k, input logic [7:0] b);
      csv_token_type t;
      t.kind        = k;
      t.data_byte   = (k == KIND_DATA) ? b : 8'd0;
      t.field_index = field_no;
      t.last        = 1'b0;
      beat_tokens.insert(beat_tokens.size(), t);
   endfunction

   function void close_field();
      push_token(KIND_FIELD, 8'd0);
      if (field_no < FIELD_CAP) field_no = field_no + 6'd1;
      scan_mode = MODE_UNQUOTED;
   endfunction

   function void close_record();
      push_token(KIND_RECORD, 8'd0);
      field_no  = 6'd0;
      scan_mode = MODE_UNQUOTED;
   endfunction

   // Delimiter test wins outside quotes; quote test wins inside them.
   function void take_char(input logic [7:0] c);
      case (scan_mode)
         MODE_QUOTED: begin
            if (c == CH_QUOTE) scan_mode = MODE_AFTERQUOTE;
            else push_token(KIND_DATA, c);
         end
         MODE_AFTERQUOTE: begin
            if (c == sep_byte) begin
               close_field();
            end else if (c == CH_QUOTE) begin
               push_token(KIND_DATA, c);
               scan_mode = MODE_QUOTED;
            end else if (c == CH_LF) begin
               close_record();
            end else begin
               scan_mode = MODE_UNQUOTED;
            end
         end
         default: begin
            if (c == sep_byte) close_field();
            else if (c == CH_LF) close_record();
            else if (c == CH_QUOTE) scan_mode = MODE_QUOTED;
            else push_token(KIND_DATA, c);
         end
      endcase
   endfunction

   // Work out every token one input beat causes and queue them in order.
   function void split_beat(input logic [7:0] b, input logic eos);
      beat_tokens.delete();
      if (eos) begin
         if (cr_waiting) begin
            cr_waiting = 1'b0;
            take_char(CH_CR);
         end
         close_record();
      end else begin
         if (cr_waiting) begin
            cr_waiting = 1'b0;
            if (!(b == CH_LF && scan_mode != MODE_QUOTED)) take_char(CH_CR);
         end
         if (b == CH_CR && scan_mode != MODE_QUOTED) cr_waiting = 1'b1;
         else take_char(b);
      end
      if (beat_tokens.size() > 0) beat_tokens[beat_tokens.size() - 1].last = 1'b1;
      foreach (beat_tokens[i]) parsed_tokens.insert(parsed_tokens.size(), beat_tokens[i]);
   endfunction

   task report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      csv_token_type want;
      if (reset) begin
         scan_mode  = MODE_UNQUOTED;
         field_no   = 6'd0;
         cr_waiting = 1'b0;
         sep_byte   = DELIMITER_RESET;
         parsed_tokens.delete();
      end else begin
         if (csr_wr_en) sep_byte = csr_wr_data;
         if (req_valid && !req_stall) split_beat(req_in_byte, req_end_of_stream);
         if (rsp_valid && !rsp_stall) begin
            if (parsed_tokens.size() == 0) begin
               report_mismatch($sformatf("result beat kind %0d byte %02h field %0d with none due",
                                         rsp_kind, rsp_data_byte, rsp_field_index));
            end else begin
               want = parsed_tokens.pop_front();
               if (rsp_kind !== want.kind || rsp_data_byte !== want.data_byte ||
                   rsp_field_index !== want.field_index || rsp_last !== want.last) begin
                  report_mismatch($sformatf(
                     "got kind %0d byte %02h field %0d last %0b, want %0d %02h %0d %0b",
                     rsp_kind, rsp_data_byte, rsp_field_index, rsp_last,
                     want.kind, want.data_byte, want.field_index, want.last));
               end
            end
         end
      end
      tokens_owed = parsed_tokens.size();
   end

endmodule

// File: dv/tb_csv_field_splitter.sv
`timescale 1ns / 100ps

module tb_csv_field_splitter;
   import csvfs_pkg::*;

   localparam int RESET_CYCLES    = 10;
   localparam int ITEMS_PER_PHASE = 185;
   // Beats that cause no result may still be in flight once the last result
   // is out; such a beat only updates the front registers, so this is ample.
   localparam int SETTLE_CYCLES   = 10;
   // Receiver hold-off, long enough to fill the result queue and stall input.
   localparam int HOLD_OFF_CYCLES = 300;
   // Longest legal quiet stretch is the hold-off above; allow plenty beyond it.
   localparam int WATCHDOG_LIMIT  = 2000;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        req_end_of_stream;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [5:0]  rsp_field_index;
   logic        rsp_last;

   int          fail_count;
   int          tokens_owed;
   int          beats_sent;
   int          send_burst_left;
   logic [7:0]  sep_now;
   logic [7:0]  phase_seps [9];

   csv_field_splitter u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_field_index   (rsp_field_index),
      .rsp_last          (rsp_last)
   );

   csv_field_splitter_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_field_index   (rsp_field_index),
      .rsp_last          (rsp_last),
      .fail_count        (fail_count),
      .tokens_owed       (tokens_owed)
   );

   // 10 ns period.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one beat and hold it until it is taken. Enter and leave at a
   // falling edge, so each input changes only there and once per step.
   // The gap before the beat is drawn fresh; now and then a burst of
   // back-to-back beats runs with no gap at all.
   task automatic send_beat(input logic [7:0] b, input logic eos);
      int gap;
      if (send_burst_left > 0) begin
         gap = 0;
         send_burst_left--;
      end else begin
         gap = $urandom_range(0, 15);
         if ($urandom_range(0, 15) == 0) send_burst_left = $urandom_range(20, 60);
      end
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= b;
      req_end_of_stream <= eos;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      @(negedge clock);
   endtask

   // Any byte with no special meaning under the current delimiter.
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom);
      while (b == sep_now || b == CH_QUOTE || b == CH_LF || b == CH_CR);
      return b;
   endfunction

   // One field: either bare text, or quoted text that may carry delimiters,
   // line breaks and doubled quotes, sometimes with a stray byte after the
   // closing quote (which the block should drop).
   task automatic send_field(input bit tiny);
      int len;
      len = tiny ? $urandom_range(0, 1) : $urandom_range(0, 6);
      if ($urandom_range(0, 2) == 0) begin
         send_beat(CH_QUOTE, 1'b0);
         repeat (len) begin
            case ($urandom_range(0, 7))
               0: begin
                  send_beat(CH_QUOTE, 1'b0);
                  send_beat(CH_QUOTE, 1'b0);
               end
               1: send_beat(sep_now, 1'b0);
               2: send_beat(CH_LF, 1'b0);
               3: send_beat(CH_CR, 1'b0);
               default: send_beat(plain_byte(), 1'b0);
            endcase
         end
         send_beat(CH_QUOTE, 1'b0);
         if ($urandom_range(0, 5) == 0) send_beat(plain_byte(), 1'b0);
      end else begin
         repeat (len) send_beat(plain_byte(), 1'b0);
      end
   endtask

   // One well-formed record. Now and then a wide one may drive the field index
   // into saturation. Close with LF, CRLF, end of stream, or CR then end.
   task automatic send_record();
      int nfields;
      int ending;
      bit wide;
      wide    = ($urandom_range(0, 19) == 0);
      nfields = wide ? $urandom_range(60, 70) : $urandom_range(1, 6);
      for (int f = 0; f < nfields; f++) begin
         if (f != 0) send_beat(sep_now, 1'b0);
         send_field(wide);
      end
      ending = $urandom_range(0, 9);
      if (ending == 6 || ending == 7 || ending == 9) send_beat(CH_CR, 1'b0);
      if (ending <= 7) send_beat(CH_LF, 1'b0);
      else send_beat(8'($urandom), 1'b1);
   endtask

   // Stop offering, let every owed result out, then give any beat that
   // causes no result time to clear the pipe.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (tokens_owed != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Result side: draw a stall for every beat, with bursts of no stall, and
   // at a few points hold off for a long stretch while the sender keeps
   // offering, so the queue fills and the input stalls.
   initial begin
      int wait_cycles;
      int burst_left;
      int beats_taken;
      rsp_stall   = 1'b0;
      burst_left  = 0;
      beats_taken = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (beats_taken == 250 || beats_taken == 900 || beats_taken == 1600) begin
            wait_cycles = HOLD_OFF_CYCLES;
         end else if (burst_left > 0) begin
            wait_cycles = 0;
            burst_left--;
         end else begin
            wait_cycles = $urandom_range(0, 15);
            if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(20, 60);
         end
         repeat (wait_cycles) begin
            rsp_stall <= 1'b1;
            @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         beats_taken++;
         @(negedge clock);
      end
   end

   // Watchdog: count edges at which no beat moves and no register is written.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[%0t] watchdog: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin
      int target;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = 8'd0;
      req_valid         = 1'b0;
      req_in_byte       = 8'd0;
      req_end_of_stream = 1'b0;
      beats_sent        = 0;
      send_burst_left   = 0;
      sep_now           = DELIMITER_RESET;
      // The reset delimiter and the extremes first, then the awkward ones: delimiter
      // equal to quote, LF and CR, then ordinary choices and one random pick.
      phase_seps = '{DELIMITER_RESET, 8'h00, 8'hFF, CH_QUOTE, CH_LF, CH_CR,
                     8'h09, 8'h3B, 8'h00};
      phase_seps[8] = 8'($urandom_range(0, 255));

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed run under the reset delimiter (comma).
      send_beat(8'h00, 1'b0);            // lowest byte as field data
      send_beat(8'hFF, 1'b0);            // highest byte as field data
      send_beat(DELIMITER_RESET, 1'b0);  // end a bare field
      send_beat(CH_QUOTE, 1'b0);         // open a quoted field
      send_beat(DELIMITER_RESET, 1'b0);  // delimiter inside quotes is data
      send_beat(CH_LF, 1'b0);            // LF inside quotes is data
      send_beat(CH_CR, 1'b0);            // CR inside quotes is data, not held
      send_beat(CH_QUOTE, 1'b0);         // closing quote
      send_beat(CH_QUOTE, 1'b0);         // doubled quote yields one quote
      send_beat(CH_QUOTE, 1'b0);         // close again
      send_beat(8'h7A, 1'b0);            // stray byte after closing quote: dropped
      send_beat(CH_QUOTE, 1'b0);         // quote within a bare field opens quotes
      send_beat(CH_QUOTE, 1'b0);         // close at once: empty quoted content
      send_beat(DELIMITER_RESET, 1'b0);  // delimiter straight after closing quote
      send_beat(CH_QUOTE, 1'b0);
      send_beat(CH_QUOTE, 1'b0);
      send_beat(CH_LF, 1'b0);            // LF after closing quote ends the record
      send_beat(CH_CR, 1'b0);            // hold CR
      send_beat(CH_LF, 1'b0);            // CRLF: CR removed, record ends
      send_beat(CH_CR, 1'b0);
      send_beat(8'h55, 1'b0);            // held CR released as data before 'U'
      send_beat(CH_CR, 1'b0);
      send_beat(CH_CR, 1'b0);            // release one CR, hold the next
      send_beat(8'hA5, 1'b1);            // end of stream flushes CR, closes record
      send_beat(8'h5A, 1'b1);            // end of stream on an empty record
      send_beat(CH_QUOTE, 1'b0);
      send_beat(8'h00, 1'b1);            // end of stream inside an open quote

      // Random phases, one delimiter each, written only once the block is idle.
      for (int p = 0; p < 9; p++) begin
         drain_results();
         csr_wr_en   <= 1'b1;
         csr_wr_data <= phase_seps[p];
         sep_now      = phase_seps[p];
         @(negedge clock);
         csr_wr_en <= 1'b0;
         target = beats_sent + ITEMS_PER_PHASE;
         while (beats_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise: raw bytes, the odd end of stream among them
               repeat ($urandom_range(1, 6))
                  send_beat(8'($urandom), $urandom_range(0, 31) == 0);
            end else begin
               send_record();
            end
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: csv_field_splitter.f
hdl/csvfs_pkg.sv
hdl/csvfs_front.sv
hdl/csvfs_queue.sv
hdl/csvfs_back.sv
hdl/csv_field_splitter.sv
dv/csv_field_splitter_checker.sv
dv/tb_csv_field_splitter.sv
